FILE: sv/cqsr_pkg.sv
`timescale 1ns / 1ps
package cqsr_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_DELETE  = 2'd1,
        FUNC_MODIFY  = 2'd2,
        FUNC_DISPLAY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DEL_RD,
        S_WALK
    } t_state;

    typedef struct packed {
        logic                     valid;
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_result;

endpackage

FILE: sv/cqsr_in_if.sv
`timescale 1ns / 1ps
interface cqsr_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          func;
    logic signed [cqsr_pkg::DATA_W-1:0]  value;
    logic signed [cqsr_pkg::DATA_W-1:0]  old_value;

    modport source (output valid, output func, output value, output old_value, input ready);
    modport sink   (input valid, input func, input value, input old_value, output ready);
endinterface

FILE: sv/cqsr_out_if.sv
`timescale 1ns / 1ps
interface cqsr_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [cqsr_pkg::DATA_W-1:0]  data;
    logic                                last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

FILE: sv/cqsr_mem.sv
`timescale 1ns / 1ps
module cqsr_mem #(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [IW-1:0]                      i_wr_addr,
    input  logic signed [cqsr_pkg::DATA_W-1:0] i_wr_data,
    input  logic                               i_rd_en,
    input  logic [IW-1:0]                      i_rd_addr,
    output logic signed [cqsr_pkg::DATA_W-1:0] o_rd_data
);

    logic signed [cqsr_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [cqsr_pkg::DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/cqsr_seq.sv
`timescale 1ns / 1ps
module cqsr_seq #(
    parameter int DEPTH = 8,
    parameter int IW    = 3,
    parameter int CW    = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  cqsr_pkg::t_func                    i_func,
    input  logic signed [cqsr_pkg::DATA_W-1:0] i_value,
    input  logic signed [cqsr_pkg::DATA_W-1:0] i_old_value,
    input  logic                               i_out_free,
    output cqsr_pkg::t_result                  o_res,
    output logic                               o_wr_en,
    output logic [IW-1:0]                      o_wr_addr,
    output logic signed [cqsr_pkg::DATA_W-1:0] o_wr_data,
    output logic                               o_rd_en,
    output logic [IW-1:0]                      o_rd_addr,
    input  logic signed [cqsr_pkg::DATA_W-1:0] i_rd_data
);

    localparam logic [IW-1:0] LastIdx = IW'(DEPTH - 1);
    localparam logic [CW-1:0] Full    = CW'(DEPTH);

    cqsr_pkg::t_state                   r_state, n_state;
    cqsr_pkg::t_func                    r_func, n_func;
    logic signed [cqsr_pkg::DATA_W-1:0] r_value, n_value;
    logic signed [cqsr_pkg::DATA_W-1:0] r_old, n_old;
    logic [IW-1:0]                      r_head, n_head;
    logic [IW-1:0]                      r_tail, n_tail;
    logic [CW-1:0]                      r_count, n_count;
    logic [IW-1:0]                      r_ptr, n_ptr;
    logic [CW-1:0]                      r_left, n_left;
    logic                               match;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx);
        return (idx == LastIdx) ? '0 : idx + 1'b1;
    endfunction

    // the one comparator, shared by every step of the modify walk
    assign match = (i_rd_data == r_old);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cqsr_pkg::S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_ptr   <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_value <= n_value;
        r_old   <= n_old;
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_value    = r_value;
        n_old      = r_old;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_left     = r_left;
        o_in_ready = 1'b0;
        o_res      = '0;
        o_wr_en    = 1'b0;
        o_wr_addr  = r_ptr;
        o_wr_data  = r_value;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_head;

        unique case (r_state)
            cqsr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_func  = i_func;
                    n_value = i_value;
                    n_old   = i_old_value;
                    n_state = cqsr_pkg::S_EXEC;
                end
            end

            cqsr_pkg::S_EXEC: begin
                unique case (r_func)
                    cqsr_pkg::FUNC_INSERT: begin
                        if (i_out_free) begin
                            o_res.valid = 1'b1;
                            o_res.last  = 1'b1;
                            n_state     = cqsr_pkg::S_IDLE;
                            if (r_count == Full) begin
                                o_res.status = cqsr_pkg::ST_FULL;
                            end else begin
                                o_res.status = cqsr_pkg::ST_OK;
                                o_wr_en      = 1'b1;
                                // an empty queue restarts at index zero
                                if (r_count == '0) begin
                                    o_wr_addr = '0;
                                    n_head    = '0;
                                    n_tail    = '0;
                                end else begin
                                    o_wr_addr = f_next(r_tail);
                                    n_tail    = f_next(r_tail);
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                    cqsr_pkg::FUNC_DELETE,
                    cqsr_pkg::FUNC_MODIFY,
                    cqsr_pkg::FUNC_DISPLAY: begin
                        if (r_count == '0) begin
                            if (i_out_free) begin
                                o_res.valid  = 1'b1;
                                o_res.status = cqsr_pkg::ST_EMPTY;
                                o_res.last   = 1'b1;
                                n_state      = cqsr_pkg::S_IDLE;
                            end
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = r_head;
                            n_ptr     = r_head;
                            n_left    = r_count;
                            n_state   = (r_func == cqsr_pkg::FUNC_DELETE) ?
                                        cqsr_pkg::S_DEL_RD : cqsr_pkg::S_WALK;
                        end
                    end
                    default: begin
                        n_state = cqsr_pkg::S_IDLE;
                    end
                endcase
            end

            cqsr_pkg::S_DEL_RD: begin
                if (i_out_free) begin
                    o_res.valid  = 1'b1;
                    o_res.status = cqsr_pkg::ST_OK;
                    o_res.data   = i_rd_data;
                    o_res.last   = 1'b1;
                    n_state      = cqsr_pkg::S_IDLE;
                    n_count      = r_count - 1'b1;
                    // last entry out: indices stay put
                    if (r_count != CW'(1)) begin
                        n_head = f_next(r_head);
                    end
                end
            end

            cqsr_pkg::S_WALK: begin
                if (r_func == cqsr_pkg::FUNC_DISPLAY) begin
                    if (i_out_free) begin
                        o_res.valid  = 1'b1;
                        o_res.status = cqsr_pkg::ST_OK;
                        o_res.data   = i_rd_data;
                        o_res.last   = (r_left == CW'(1));
                        if (r_left == CW'(1)) begin
                            n_state = cqsr_pkg::S_IDLE;
                        end else begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = f_next(r_ptr);
                            n_ptr     = f_next(r_ptr);
                            n_left    = r_left - 1'b1;
                        end
                    end
                end else if (match) begin
                    if (i_out_free) begin
                        o_wr_en      = 1'b1;
                        o_wr_addr    = r_ptr;
                        o_res.valid  = 1'b1;
                        o_res.status = cqsr_pkg::ST_OK;
                        o_res.last   = 1'b1;
                        n_state      = cqsr_pkg::S_IDLE;
                    end
                end else if (r_left == CW'(1)) begin
                    if (i_out_free) begin
                        o_res.valid  = 1'b1;
                        o_res.status = cqsr_pkg::ST_NOT_FOUND;
                        o_res.last   = 1'b1;
                        n_state      = cqsr_pkg::S_IDLE;
                    end
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = f_next(r_ptr);
                    n_ptr     = f_next(r_ptr);
                    n_left    = r_left - 1'b1;
                end
            end

            default: begin
                n_state = cqsr_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Full)
        else $error("entry count above depth");

    a_res_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> i_out_free)
        else $error("result issued while output register busy");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |=> (r_state == cqsr_pkg::S_IDLE))
        else $error("sequencer not idle after final result");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cqsr_pkg::S_WALK) |-> (r_left != '0 && r_left <= r_count))
        else $error("walk counter out of range");

    a_write_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && r_state == cqsr_pkg::S_EXEC) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the queue");
`endif

endmodule

FILE: sv/circular_queue_with_search_replace_core.sv
`timescale 1ns / 1ps
// Circular queue of signed 32-bit words with insert, delete, modify and display.
// Input channel i_in carries func, value and old_value; output channel o_out
// carries status, data and last, one transfer per result. last marks the final
// result of an item; display gives one result per stored entry, every other
// operation exactly one.
// The block takes one item at a time: i_in.ready is high only while the
// sequencer is idle. Insert writes the entry and loads its result from the
// execute state; delete reads the head entry, then loads it as the result;
// modify and display step across the stored entries from the head, one
// read at a time, set by the single read port of the entry memory and the
// one comparator; delete, modify and display on an empty queue answer from
// the execute state. Every result passes through the output register.
// A stalled receiver holds the result in the output register; the sequencer
// waits there and resumes without loss once o_out.ready returns.
// Synchronous active-low reset empties the queue and zeroes head and tail;
// entry contents are left as they are and never read before being written.
module circular_queue_with_search_replace_core #(
    parameter int DEPTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cqsr_in_if.sink   i_in,
    cqsr_out_if.source o_out
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cqsr_pkg::t_result                  res;
    logic                               out_free;
    logic                               wr_en;
    logic [IW-1:0]                      wr_addr;
    logic signed [cqsr_pkg::DATA_W-1:0] wr_data;
    logic                               rd_en;
    logic [IW-1:0]                      rd_addr;
    logic signed [cqsr_pkg::DATA_W-1:0] rd_data;

    logic                               r_out_valid;
    cqsr_pkg::t_status                  r_status;
    logic signed [cqsr_pkg::DATA_W-1:0] r_data;
    logic                               r_last;

    assign out_free = !r_out_valid || o_out.ready;

    cqsr_seq #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .CW    (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_func      (cqsr_pkg::t_func'(i_in.func)),
        .i_value     (i_in.value),
        .i_old_value (i_in.old_value),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    cqsr_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_status <= res.status;
            r_data   <= res.data;
            r_last   <= res.last;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.data   = r_data;
    assign o_out.last   = r_last;

endmodule
